[hw/rtl/tpps_pkg.sv]
// ----------------------------------------------------------------------------
// Tone period prescale select: shared definitions
// Widths, status codes, the prescaler shift table and the beat format that
// pass between the divider stages and the prescaler selection stages.
// ----------------------------------------------------------------------------
package tpps_pkg;

    // Field widths.
    localparam int CLOCK_W   = 31;
    localparam int FREQ_W    = 16;
    localparam int QUOT_W    = CLOCK_W + 1;
    localparam int COUNT_W   = CLOCK_W;
    localparam int PERIOD_W  = 16;
    localparam int COMPARE_W = 15;
    localparam int INDEX_W   = 3;
    localparam int STATUS_W  = 2;

    // Reset value of the clock rate register.
    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 31'd32000000;

    // Default number of quotient bits produced by one divider stage.
    localparam int DIV_BITS_PER_STAGE = 4;

    // Prescalers, fastest first, and the rounded shift applied before each test.
    localparam int NUM_PRESCALERS = 7;
    localparam int SEL_SPLIT      = 4;
    localparam int PRESCALE_SHIFT [NUM_PRESCALERS] = '{0, 1, 1, 1, 3, 2, 2};

    // Largest count that a 16-bit period can hold.
    localparam logic [COUNT_W-1:0] FIT_LIMIT = 31'h10000;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OFF     = 2'd1,
        STATUS_TOO_LOW = 2'd2
    } t_status;

    // Partial division state: the remainder, the dividend shifting out at the
    // top while the quotient shifts in at the bottom, and the divisor.
    typedef struct packed {
        logic               zero;
        logic [FREQ_W-1:0]  rem;
        logic [QUOT_W-1:0]  dq;
        logic [FREQ_W-1:0]  divisor;
    } t_div_beat;

endpackage

[hw/rtl/tone_period_prescale_select.sv]
// ----------------------------------------------------------------------------
// Tone period prescale select
// Picks the fastest timer prescaler and the 16-bit period and half-duty
// compare value that produce a requested tone from the configured clock.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     i_valid / o_ready         i_frequency
//  result    o_valid / i_ready         o_status, o_prescaler_index,
//                                      o_period_value, o_compare_value
//  config    i_cfg_we                  i_cfg_data (clock rate in hertz)
//
// One beat is accepted every cycle while the result side does not stall;
// each beat passes through the divider stages, each of which resolves
// DIV_BITS quotient bits, and then through the prescaler selection stages.
// Reset empties every stage and loads the clock rate with 32 MHz.
// A stall holds only the stages that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
module tone_period_prescale_select
    import tpps_pkg::*;
#(
    parameter int DIV_BITS = DIV_BITS_PER_STAGE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CLOCK_W-1:0]   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FREQ_W-1:0]    i_frequency,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [INDEX_W-1:0]   o_prescaler_index,
    output logic [PERIOD_W-1:0]  o_period_value,
    output logic [COMPARE_W-1:0] o_compare_value
);

    localparam int DIV_STAGES = QUOT_W / DIV_BITS;

    logic [CLOCK_W-1:0] r_clock_hz;
    logic               stg_valid [DIV_STAGES+1];
    logic               stg_ready [DIV_STAGES+1];
    t_div_beat          stg_beat  [DIV_STAGES+1];

    // Clock rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    // Division of twice the clock rate by the frequency starts here.
    assign stg_valid[0]        = i_valid;
    assign o_ready             = stg_ready[0];
    assign stg_beat[0].zero    = (i_frequency == '0);
    assign stg_beat[0].rem     = '0;
    assign stg_beat[0].dq      = {r_clock_hz, 1'b0};
    assign stg_beat[0].divisor = i_frequency;

    // Divider pipeline.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        tpps_div_stage #(
            .BITS (DIV_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_beat  (stg_beat[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_beat  (stg_beat[g+1])
        );
    end

    // Rounding, prescaler walk and result register.
    tpps_select u_select (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (stg_valid[DIV_STAGES]),
        .o_ready           (stg_ready[DIV_STAGES]),
        .i_beat            (stg_beat[DIV_STAGES]),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_prescaler_index (o_prescaler_index),
        .o_period_value    (o_period_value),
        .o_compare_value   (o_compare_value)
    );

`ifndef NO_ASSERTIONS
    // An off or too-low result carries no setting.
    a_idle_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STATUS_OK) |->
            (o_prescaler_index == '0) && (o_period_value == '0))
        else $error("off or too-low result carries a setting");

    // Only the three defined status codes leave the block.
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK) || (o_status == STATUS_OFF) ||
                    (o_status == STATUS_TOO_LOW))
        else $error("undefined status code");

    // A chosen prescaler is one of the seven.
    a_index_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_OK) |->
            (o_prescaler_index < INDEX_W'(NUM_PRESCALERS)))
        else $error("prescaler index out of range");

    // The pipeline is empty in the cycle after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

[hw/rtl/tpps_div_stage.sv]
// ----------------------------------------------------------------------------
// Tone period prescale select: divider stage
// One registered stage of the restoring divider, producing BITS quotient
// bits per beat, with its own valid bit and stall handling.
// ----------------------------------------------------------------------------
module tpps_div_stage
    import tpps_pkg::*;
#(
    parameter int BITS = DIV_BITS_PER_STAGE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_beat i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_beat o_beat
);

    logic      r_valid;
    t_div_beat r_beat;
    t_div_beat n_beat;

    // The stage can take a beat when it is empty or its beat moves on.
    assign o_ready = !r_valid || i_ready;

    // Restoring division steps: shift one dividend bit into the remainder,
    // subtract the divisor where it fits and record the quotient bit.
    always_comb begin
        logic [FREQ_W:0] trial;
        n_beat = i_beat;
        for (int k = 0; k < BITS; k++) begin
            trial     = {n_beat.rem, n_beat.dq[QUOT_W-1]};
            n_beat.dq = {n_beat.dq[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, n_beat.divisor}) begin
                trial        = trial - {1'b0, n_beat.divisor};
                n_beat.dq[0] = 1'b1;
            end
            n_beat.rem = trial[FREQ_W-1:0];
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register of the stage.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[hw/rtl/tpps_select.sv]
// ----------------------------------------------------------------------------
// Tone period prescale select: prescaler selection
// Rounds the quotient to a count, walks the prescaler chain over two
// registered stages and forms the period and compare values.
// ----------------------------------------------------------------------------
module tpps_select
    import tpps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_div_beat            i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [INDEX_W-1:0]   o_prescaler_index,
    output logic [PERIOD_W-1:0]  o_period_value,
    output logic [COMPARE_W-1:0] o_compare_value
);

    // Halving with rounding: an odd value rounds up.
    function automatic logic [COUNT_W-1:0] half_round(input logic [COUNT_W-1:0] v);
        return (v >> 1) + {{(COUNT_W-1){1'b0}}, v[0]};
    endfunction

    // Rounded shift: drop s-1 bits, then halve with rounding.
    function automatic logic [COUNT_W-1:0] shift_round(input logic [COUNT_W-1:0] v,
                                                       input int s);
        if (s == 0) begin
            return v;
        end
        return half_round(v >> (s - 1));
    endfunction

    // First stage registers.
    logic                 r_a_valid;
    logic                 r_a_zero;
    logic                 r_a_found;
    logic [INDEX_W-1:0]   r_a_index;
    logic [COUNT_W-1:0]   r_a_count;
    logic [COUNT_W-1:0]   r_a_chain;
    logic                 a_ready;

    logic                 n_a_found;
    logic [INDEX_W-1:0]   n_a_index;
    logic [COUNT_W-1:0]   n_a_count;
    logic [COUNT_W-1:0]   n_a_chain;

    // Output stage registers.
    logic                 r_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [INDEX_W-1:0]   r_index;
    logic [PERIOD_W-1:0]  r_period;

    t_status              n_status;
    logic [INDEX_W-1:0]   n_index;
    logic [PERIOD_W-1:0]  n_period;
    logic                 b_found;
    logic [COUNT_W-1:0]   b_count;
    logic [COUNT_W-1:0]   b_chain;
    logic [COUNT_W-1:0]   b_less1;

    assign o_ready = !r_a_valid || a_ready;
    assign a_ready = !r_valid || i_ready;

    // First stage: round the quotient and try the fastest prescalers.
    always_comb begin
        n_a_chain = i_beat.dq[QUOT_W-1:1] + {{(COUNT_W-1){1'b0}}, i_beat.dq[0]};
        n_a_found = 1'b0;
        n_a_index = '0;
        n_a_count = '0;
        for (int k = 0; k < SEL_SPLIT; k++) begin
            n_a_chain = shift_round(n_a_chain, PRESCALE_SHIFT[k]);
            if (!n_a_found && (n_a_chain <= FIT_LIMIT)) begin
                n_a_found = 1'b1;
                n_a_index = INDEX_W'(k);
                n_a_count = n_a_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_zero  <= i_beat.zero;
            r_a_found <= n_a_found;
            r_a_index <= n_a_index;
            r_a_count <= n_a_count;
            r_a_chain <= n_a_chain;
        end
    end

    // Second stage: try the slow prescalers where none fitted, then decide.
    always_comb begin
        b_found = r_a_found;
        n_index = r_a_index;
        b_count = r_a_count;
        b_chain = r_a_chain;
        for (int k = SEL_SPLIT; k < NUM_PRESCALERS; k++) begin
            b_chain = shift_round(b_chain, PRESCALE_SHIFT[k]);
            if (!b_found && (b_chain <= FIT_LIMIT)) begin
                b_found = 1'b1;
                n_index = INDEX_W'(k);
                b_count = b_chain;
            end
        end
        b_less1  = b_count - {{(COUNT_W-1){1'b0}}, 1'b1};
        n_period = b_less1[PERIOD_W-1:0];
        n_status = STATUS_OK;
        if (r_a_zero) begin
            n_status = STATUS_OFF;
            n_index  = '0;
            n_period = '0;
        end else if (!b_found) begin
            n_status = STATUS_TOO_LOW;
            n_index  = '0;
            n_period = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (a_ready) begin
            r_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && r_a_valid) begin
            r_status <= n_status;
            r_index  <= n_index;
            r_period <= n_period;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_prescaler_index = r_index;
    assign o_period_value    = r_period;
    assign o_compare_value   = r_period[PERIOD_W-1:1];

endmodule

[tb/sv/tone_period_prescale_select_tb.sv]
// ----------------------------------------------------------------------------
// Tone period prescale select: testbench
// Sends tone frequency requests through the valid/ready input, predicts the
// prescaler, period and compare value for each accepted beat from the clock
// rate last written, and checks every result beat in order against that
// prediction. Both sides idle at random, the receiver also holds off for a
// long stretch, and the clock rate is changed between phases while the block
// is empty.
// ----------------------------------------------------------------------------
module tone_period_prescale_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpps_pkg::*;

    // Rounded shift before each prescaler test, fastest prescaler first.
    localparam int NUM_DIVIDERS = 7;
    localparam int DIVIDER_ROUND_SHIFT [NUM_DIVIDERS] = '{0, 1, 1, 1, 3, 2, 2};
    localparam logic [63:0] MAX_TIMER_COUNT = 64'h10000;

    localparam int RESET_CYCLES      = 9;
    localparam int SETTLE_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES  = 120;
    localparam int RANDOM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE   = 220;
    localparam int PRESSURE_ITEMS    = 140;

    localparam logic [CLOCK_W-1:0] CLOCK_RATE_MIN = 31'd1000000;
    localparam logic [CLOCK_W-1:0] CLOCK_RATE_MAX = 31'h7FFFFFFF;

    // Frequencies around the prescaler boundaries at the 32 MHz reset rate.
    localparam logic [FREQ_W-1:0] RESET_RATE_CORNERS [12] =
        '{16'd0, 16'd1, 16'd65535, 16'd32768, 16'd489, 16'd488,
          16'd245, 16'd244, 16'd62, 16'd61, 16'd8, 16'd7};

    typedef struct packed {
        t_status                status;
        logic [INDEX_W-1:0]     index;
        logic [PERIOD_W-1:0]    period;
        logic [COMPARE_W-1:0]   compare;
    } t_timer_setting;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CLOCK_W-1:0]   i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [FREQ_W-1:0]    i_frequency = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [INDEX_W-1:0]   o_prescaler_index;
    logic [PERIOD_W-1:0]  o_period_value;
    logic [COMPARE_W-1:0] o_compare_value;

    // Predictor state and the queue of settings still to come out.
    logic [CLOCK_W-1:0]   clock_rate_hz = CLOCK_HZ_RESET;
    t_timer_setting       timer_settings_due [$];

    // Sender burst control, receiver hold-off requests and run statistics.
    int   burst_left = 0;
    bit   sender_gaps = 1'b1;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    logic [31:0] ready_cycle = '0;
    int   failures = 0;
    int   requests_sent = 0;
    int   results_checked = 0;
    int   clock_settings = 1;
    int   input_stall_cycles = 0;
    int   status_tally [3] = '{0, 0, 0};

    tone_period_prescale_select u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_frequency       (i_frequency),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_prescaler_index (o_prescaler_index),
        .o_period_value    (o_period_value),
        .o_compare_value   (o_compare_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Works out the timer setting for one frequency at the given clock rate.
    function automatic t_timer_setting predict_timer_setting(
        input logic [CLOCK_W-1:0] rate_hz,
        input logic [FREQ_W-1:0]  freq
    );
        t_timer_setting setting;
        logic [63:0]    count;
        logic [63:0]    period;
        setting = '{STATUS_OK, '0, '0, '0};
        if (freq == '0) begin
            setting.status = STATUS_OFF;
            return setting;
        end
        // Twice the clock over the frequency, halved with the odd bit rounding up.
        count = ({33'd0, rate_hz} << 1) / {48'd0, freq};
        count = (count >> 1) + {63'd0, count[0]};
        for (int i = 0; i < NUM_DIVIDERS; i++) begin
            if (DIVIDER_ROUND_SHIFT[i] != 0) begin
                count = count >> (DIVIDER_ROUND_SHIFT[i] - 1);
                count = (count >> 1) + {63'd0, count[0]};
            end
            if (count <= MAX_TIMER_COUNT) begin
                // A zero count wraps to the full period.
                period          = count - 64'd1;
                setting.index   = INDEX_W'(i);
                setting.period  = period[PERIOD_W-1:0];
                setting.compare = period[PERIOD_W-1:1];
                return setting;
            end
        end
        setting.status = STATUS_TOO_LOW;
        return setting;
    endfunction

    // A mix of zero, low, power-of-two and full-range frequencies.
    function automatic logic [FREQ_W-1:0] pick_frequency();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return FREQ_W'($urandom_range(1, 255));
            3:       return FREQ_W'($urandom_range(1, 2048));
            4:       return FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
            default: return FREQ_W'($urandom());
        endcase
    endfunction

    // Offers one frequency and returns in the step at which the beat is taken.
    task automatic send_frequency(input logic [FREQ_W-1:0] freq);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_frequency <= freq;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        timer_settings_due.push_back(predict_timer_setting(clock_rate_hz, freq));
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted setting has come out.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (timer_settings_due.size() != 0) @(posedge i_clk);
    endtask

    // Writes the clock rate once the block has emptied.
    task automatic set_clock_rate(input logic [CLOCK_W-1:0] rate_hz);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rate_hz;
        @(posedge i_clk);
        clock_rate_hz = rate_hz;
        clock_settings++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            failures++;
        end
    endtask

    // Prescaler boundaries, zero and the largest frequency at the reset rate.
    task automatic test_reset_rate_corners();
        foreach (RESET_RATE_CORNERS[i]) send_frequency(RESET_RATE_CORNERS[i]);
    endtask

    // Fastest and slowest legal clocks, then clocks so slow the count is zero or one.
    task automatic test_clock_extremes();
        set_clock_rate(CLOCK_RATE_MAX);
        send_frequency(16'd1);
        send_frequency(16'd2);
        send_frequency(16'd3);
        send_frequency(16'd0);
        send_frequency(16'd65535);
        set_clock_rate(CLOCK_RATE_MIN);
        send_frequency(16'd1);
        send_frequency(16'd65535);
        send_frequency(16'd15);
        send_frequency(16'd16);
        set_clock_rate('0);
        send_frequency(16'd1);
        send_frequency(16'd65535);
        set_clock_rate(31'd1);
        send_frequency(16'd1);
        send_frequency(16'd65535);
    endtask

    // Random frequencies over several clock rates, with and without sender gaps.
    task automatic test_random_requests();
        logic [CLOCK_W-1:0] rate_hz;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       rate_hz = CLOCK_HZ_RESET;
                1:       rate_hz = CLOCK_RATE_MAX;
                2:       rate_hz = CLOCK_RATE_MIN;
                3:       rate_hz = CLOCK_W'($urandom_range(0, 999999));
                default: rate_hz = CLOCK_W'($urandom_range(CLOCK_RATE_MIN, CLOCK_RATE_MAX));
            endcase
            set_clock_rate(rate_hz);
            sender_gaps = (phase % 2) == 0;
            repeat (ITEMS_PER_PHASE) send_frequency(pick_frequency());
        end
        sender_gaps = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_input_backpressure();
        set_clock_rate(CLOCK_W'($urandom_range(CLOCK_RATE_MIN, CLOCK_RATE_MAX)));
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (PRESSURE_ITEMS) send_frequency(pick_frequency());
        sender_gaps = 1'b1;
    endtask

    // Receiver: a long hold-off when asked, otherwise a stall pattern chosen
    // by bits 9 to 7 of a free-running cycle counter.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (ready_cycle[9:7])
                3'd0, 3'd1: i_ready <= 1'b1;
                3'd3:       i_ready <= ($urandom_range(0, 3) == 0);
                3'd4:       i_ready <= ready_cycle[2];
                3'd5:       i_ready <= ($urandom_range(0, 7) != 0);
                default:    i_ready <= 1'(($urandom_range(0, 1)));
            endcase
        end
        ready_cycle++;
    end

    // Result checker: every accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_timer_setting want;
        if (i_rst_n && i_ready && o_valid !== 1'b0) begin
            if (timer_settings_due.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, status %0d",
                         $time, o_status);
                failures++;
            end else begin
                want = timer_settings_due.pop_front();
                results_checked++;
                status_tally[want.status]++;
                check_field("status", want.status, o_status);
                check_field("prescaler index", want.index, o_prescaler_index);
                check_field("period value", want.period, o_period_value);
                check_field("compare value", want.compare, o_compare_value);
            end
        end
        if (i_rst_n && i_valid && o_ready !== 1'b1) input_stall_cycles++;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rate_corners();
        test_clock_extremes();
        test_random_requests();
        test_input_backpressure();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d tone requests over %0d clock rate settings: %0d ok, %0d off, %0d too low.",
                 requests_sent, clock_settings, status_tally[STATUS_OK],
                 status_tally[STATUS_OFF], status_tally[STATUS_TOO_LOW]);
        $display("%0d results checked, %0d cycles with the input held back, %0d mismatches.",
                 results_checked, input_stall_cycles, failures);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[tone_period_prescale_select.f]
hw/rtl/tpps_pkg.sv
hw/rtl/tpps_div_stage.sv
hw/rtl/tpps_select.sv
hw/rtl/tone_period_prescale_select.sv
tb/sv/tone_period_prescale_select_tb.sv
